// File: design/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, codes and helpers for the script last-push parser.
// ----------------------------------------------------------------------------
package slp_pkg;

   localparam logic [15:0] MAX_SCRIPT_BYTES = 16'hFFFF;

   localparam logic [1:0] PH_OPCODE = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   localparam logic [7:0] OP_MAX_DIRECT = 8'd75;
   localparam logic [7:0] OP_LEN1_PUSH  = 8'd76;
   localparam logic [7:0] OP_LEN2_PUSH  = 8'd77;
   localparam logic [7:0] OP_LEN4_PUSH  = 8'd78;

   localparam logic [1:0] KIND_LEN1 = 2'd0;
   localparam logic [1:0] KIND_LEN2 = 2'd1;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_EMPTY      = 3'd1;
   localparam logic [2:0] STATUS_TRUNC_LEN1 = 3'd2;
   localparam logic [2:0] STATUS_TRUNC_LEN2 = 3'd3;
   localparam logic [2:0] STATUS_TRUNC_LEN4 = 3'd4;
   localparam logic [2:0] STATUS_PAST_END   = 3'd5;
   localparam logic [2:0] STATUS_NOT_PUSH   = 3'd6;
   localparam logic [2:0] STATUS_TOO_LONG   = 3'd7;

   typedef struct packed {
      logic [7:0] script_byte;
      logic       last_byte;
      logic       empty_script;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] push_start;
      logic [15:0] push_length;
   } rsp_type;

   function automatic logic [2:0] kind_total(input logic [1:0] kind);
      logic [2:0] total;
      unique case (kind)
         KIND_LEN1: total = 3'd1;
         KIND_LEN2: total = 3'd2;
         default:   total = 3'd4;
      endcase
      return total;
   endfunction

endpackage

// File: design/slp_in_stage.sv
// ----------------------------------------------------------------------------
// slp_in_stage
// Input register: holds one request until the parser takes it.
// ----------------------------------------------------------------------------
module slp_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slp_pkg::req_type req_data,
   input  logic             take,
   output logic             held_valid,
   output slp_pkg::req_type held_data
);

   logic             valid_ff;
   logic             valid_in;
   slp_pkg::req_type data_ff;
   slp_pkg::req_type data_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

// File: design/slp_parse.sv
// ----------------------------------------------------------------------------
// slp_parse
// Per-byte opcode/length/data tracking and end-of-script verdict.
// ----------------------------------------------------------------------------
module slp_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  slp_pkg::req_type item,
   output logic             done,
   output slp_pkg::rsp_type result
);

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  length_bytes_left_ff, length_bytes_left_in;
   logic [1:0]  length_kind_ff, length_kind_in;
   logic [31:0] declared_length_ff, declared_length_in;
   logic [31:0] data_bytes_left_ff, data_bytes_left_in;
   logic [15:0] position_ff, position_in;
   logic        overflow_ff, overflow_in;
   logic [15:0] last_push_start_ff, last_push_start_in;
   logic [15:0] last_push_length_ff, last_push_length_in;
   logic        last_was_push_ff, last_was_push_in;

   logic [2:0]  done_cnt;
   logic [31:0] merged_length;
   logic [7:0]  b;

   assign b = item.script_byte;

   always_comb begin
      phase_in             = phase_ff;
      length_bytes_left_in = length_bytes_left_ff;
      length_kind_in       = length_kind_ff;
      declared_length_in   = declared_length_ff;
      data_bytes_left_in   = data_bytes_left_ff;
      position_in          = position_ff;
      overflow_in          = overflow_ff;
      last_push_start_in   = last_push_start_ff;
      last_push_length_in  = last_push_length_ff;
      last_was_push_in     = last_was_push_ff;
      done                 = 1'b0;
      result               = '0;
      done_cnt             = slp_pkg::kind_total(length_kind_ff) - length_bytes_left_ff;
      merged_length        = declared_length_ff
                             | ({24'd0, b} << {done_cnt[1:0], 3'b000});

      if (step && !item.empty_script && !overflow_ff) begin
         if (position_ff >= slp_pkg::MAX_SCRIPT_BYTES) begin
            overflow_in = 1'b1;
         end else begin
            position_in = position_ff + 16'd1;
            unique case (phase_ff)
               slp_pkg::PH_LENGTH: begin
                  declared_length_in   = merged_length;
                  length_bytes_left_in = length_bytes_left_ff - 3'd1;
                  if (length_bytes_left_in == 3'd0) begin
                     last_push_start_in  = position_in;
                     last_push_length_in = merged_length[15:0];
                     last_was_push_in    = 1'b1;
                     if (merged_length != 32'd0) begin
                        data_bytes_left_in = merged_length;
                        phase_in           = slp_pkg::PH_DATA;
                     end else begin
                        phase_in = slp_pkg::PH_OPCODE;
                     end
                  end
               end
               slp_pkg::PH_DATA: begin
                  data_bytes_left_in = data_bytes_left_ff - 32'd1;
                  if (data_bytes_left_in == 32'd0) begin
                     phase_in = slp_pkg::PH_OPCODE;
                  end
               end
               default: begin
                  phase_in = slp_pkg::PH_OPCODE;
                  if (b <= slp_pkg::OP_MAX_DIRECT) begin
                     declared_length_in  = {24'd0, b};
                     last_push_start_in  = position_in;
                     last_push_length_in = {8'd0, b};
                     last_was_push_in    = 1'b1;
                     if (b != 8'd0) begin
                        data_bytes_left_in = {24'd0, b};
                        phase_in           = slp_pkg::PH_DATA;
                     end
                  end else if (b >= slp_pkg::OP_LEN1_PUSH
                               && b <= slp_pkg::OP_LEN4_PUSH) begin
                     length_kind_in       = b[1:0];
                     length_bytes_left_in = slp_pkg::kind_total(b[1:0]);
                     declared_length_in   = 32'd0;
                     last_was_push_in     = 1'b0;
                     phase_in             = slp_pkg::PH_LENGTH;
                  end else begin
                     last_was_push_in    = 1'b0;
                     last_push_start_in  = 16'd0;
                     last_push_length_in = 16'd0;
                  end
               end
            endcase
         end
      end

      if (step && (item.empty_script || item.last_byte)) begin
         done = 1'b1;
         if (overflow_in) begin
            result.status = slp_pkg::STATUS_TOO_LONG;
         end else if (position_in == 16'd0) begin
            result.status = slp_pkg::STATUS_EMPTY;
         end else if (phase_in == slp_pkg::PH_LENGTH) begin
            if (length_kind_in == slp_pkg::KIND_LEN1) begin
               result.status = slp_pkg::STATUS_TRUNC_LEN1;
            end else if (length_kind_in == slp_pkg::KIND_LEN2) begin
               result.status = slp_pkg::STATUS_TRUNC_LEN2;
            end else begin
               result.status = slp_pkg::STATUS_TRUNC_LEN4;
            end
         end else if (phase_in == slp_pkg::PH_DATA && data_bytes_left_in != 32'd0) begin
            result.status = slp_pkg::STATUS_PAST_END;
         end else if (last_was_push_in) begin
            result.status      = slp_pkg::STATUS_OK;
            result.push_start  = last_push_start_in;
            result.push_length = last_push_length_in;
         end else begin
            result.status = slp_pkg::STATUS_NOT_PUSH;
         end
         phase_in             = slp_pkg::PH_OPCODE;
         length_bytes_left_in = 3'd0;
         length_kind_in       = 2'd0;
         declared_length_in   = 32'd0;
         data_bytes_left_in   = 32'd0;
         position_in          = 16'd0;
         overflow_in          = 1'b0;
         last_push_start_in   = 16'd0;
         last_push_length_in  = 16'd0;
         last_was_push_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= slp_pkg::PH_OPCODE;
         length_bytes_left_ff <= 3'd0;
         length_kind_ff       <= 2'd0;
         declared_length_ff   <= 32'd0;
         data_bytes_left_ff   <= 32'd0;
         position_ff          <= 16'd0;
         overflow_ff          <= 1'b0;
         last_push_start_ff   <= 16'd0;
         last_push_length_ff  <= 16'd0;
         last_was_push_ff     <= 1'b0;
      end else begin
         phase_ff             <= phase_in;
         length_bytes_left_ff <= length_bytes_left_in;
         length_kind_ff       <= length_kind_in;
         declared_length_ff   <= declared_length_in;
         data_bytes_left_ff   <= data_bytes_left_in;
         position_ff          <= position_in;
         overflow_ff          <= overflow_in;
         last_push_start_ff   <= last_push_start_in;
         last_push_length_ff  <= last_push_length_in;
         last_was_push_ff     <= last_was_push_in;
      end
   end

endmodule

// File: design/script_last_push_parser.sv
// ----------------------------------------------------------------------------
// script_last_push_parser
// Streams a script one byte per request and reports the final push.
// ----------------------------------------------------------------------------
// Accepts one script byte per cycle unless a pending result stalls the input.
// A request is held in an input register and parsed once the parser takes it;
// its verdict, if it ends a script, lands in a result register, so a result
// appears in the cycle after the request that ends the script is taken.
// Throughput is one request per cycle while no result stall applies; a pending
// result that is not taken holds a request that ends a script in the input
// register, and requests behind it wait, only while rsp_ready is low.
module script_last_push_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_script_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_script,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_push_start,
   output logic [15:0] rsp_push_length
);

   slp_pkg::req_type req_data;
   slp_pkg::req_type held_data;
   slp_pkg::rsp_type result;
   slp_pkg::rsp_type rsp_ff;
   slp_pkg::rsp_type rsp_in;
   logic             held_valid;
   logic             take;
   logic             done;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   assign req_data.script_byte  = req_script_byte;
   assign req_data.last_byte    = req_last_byte;
   assign req_data.empty_script = req_empty_script;

   assign take = held_valid
                 && (!(held_data.last_byte || held_data.empty_script)
                     || !rsp_valid_ff || rsp_ready);

   slp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (take),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   slp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .item   (held_data),
      .done   (done),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_push_start  = rsp_ff.push_start;
   assign rsp_push_length = rsp_ff.push_length;

endmodule

// File: design/slp_checker.sv
// ----------------------------------------------------------------------------
// slp_checker
// Port-level checks for the script last-push parser.
// ----------------------------------------------------------------------------
module slp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_push_start,
   input logic [15:0] rsp_push_length
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or request blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_push_start) && $stable(rsp_push_length))
      else $error("stalled result changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != slp_pkg::STATUS_OK
         |-> rsp_push_start == 16'd0 && rsp_push_length == 16'd0)
      else $error("failed verdict carries push fields");

   a_ok_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == slp_pkg::STATUS_OK |-> rsp_push_start != 16'd0)
      else $error("push cannot start before its opcode");

endmodule

bind script_last_push_parser slp_checker u_slp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_push_start  (rsp_push_start),
   .rsp_push_length (rsp_push_length)
);
